FILE: rtl/core/skav_pkg.sv
// Shared types and constants of the session keepalive supervisor.
// Used by every module of the block; depends on nothing else.
package skav_pkg;

  // Command carried by an input beat.
  typedef enum logic [1:0] {
    CMD_CONNECT    = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_MESSAGE    = 2'd2,
    CMD_HOST_CLOSE = 2'd3
  } cmd_e;

  // Received message kinds.
  localparam logic [3:0] MSG_INIT_REQ   = 4'd0;
  localparam logic [3:0] MSG_INIT_RESP  = 4'd1;
  localparam logic [3:0] MSG_CLOSE_REQ  = 4'd2;
  localparam logic [3:0] MSG_CLOSE_RESP = 4'd3;
  localparam logic [3:0] MSG_KA_REQ     = 4'd4;
  localparam logic [3:0] MSG_KA_RESP    = 4'd5;
  localparam logic [3:0] MSG_PDU_FIRST  = 4'd6;
  localparam logic [3:0] MSG_PDU_LAST   = 4'd13;

  // Message class worked out by the front part.
  typedef enum logic [2:0] {
    MC_IGNORE    = 3'd0,
    MC_INIT_RESP = 3'd1,
    MC_CLOSE_REQ = 3'd2,
    MC_KA_RESP   = 3'd3,
    MC_PLAIN     = 3'd4,
    MC_FORWARD   = 3'd5
  } msg_class_e;

  typedef enum logic [2:0] {
    ACT_SEND_INIT       = 3'd0,
    ACT_SEND_CLOSE_REQ  = 3'd1,
    ACT_SEND_KEEPALIVE  = 3'd2,
    ACT_SEND_CLOSE_RESP = 3'd3,
    ACT_SUCCEEDED       = 3'd4,
    ACT_FAILED          = 3'd5,
    ACT_CLOSED          = 3'd6,
    ACT_FORWARD         = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    CFG_KA_INTERVAL     = 2'd0,
    CFG_INACT_DEFAULT   = 2'd1,
    CFG_KA_TIMEOUT      = 2'd2,
    CFG_INIT_TIMEOUT    = 2'd3
  } cfg_idx_e;

  localparam logic [31:0] KaIntervalRst   = 32'd30000;
  localparam logic [31:0] InactDefaultRst = 32'd60000;
  localparam logic [31:0] KaTimeoutRst    = 32'd15000;
  localparam logic [31:0] InitTimeoutRst  = 32'd5000;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] time_passed_ms;
    logic [3:0]  msg_kind;
    logic        msg_success;
    logic [31:0] msg_inactivity_ms;
    logic [15:0] msg_transaction_id;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] transaction_id;
    logic [31:0] inactivity_ms;
    logic        last;
  } out_item_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    cmd_e        cmd;
    msg_class_e  mclass;
    logic [15:0] time_passed_ms;
    logic        success;
    logic [31:0] inactivity_ms;
    logic [15:0] tid;
  } op_item_t;

  typedef struct packed {
    logic             not_empty;
    logic             full;
    logic [QCntW-1:0] count;
  } q_status_t;

endpackage

FILE: rtl/core/skav_front.sv
// Front part: accepts input beats and classifies command and message kind.
// Depends on skav_pkg; feeds skav_queue.
module skav_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  skav_pkg::in_item_t   in_data_i,
  input  skav_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output skav_pkg::op_item_t   op_o
);
  import skav_pkg::*;

  msg_class_e mclass;

  always_comb begin
    unique case (in_data_i.msg_kind) inside
      MSG_INIT_RESP:                   mclass = MC_INIT_RESP;
      MSG_CLOSE_REQ:                   mclass = MC_CLOSE_REQ;
      MSG_KA_RESP:                     mclass = MC_KA_RESP;
      MSG_INIT_REQ, MSG_CLOSE_RESP,
      MSG_KA_REQ:                      mclass = MC_PLAIN;
      [MSG_PDU_FIRST:MSG_PDU_LAST]:    mclass = MC_FORWARD;
      default:                         mclass = MC_IGNORE;
    endcase
  end

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    op_o.cmd            = cmd_e'(in_data_i.command);
    op_o.mclass         = mclass;
    op_o.time_passed_ms = in_data_i.time_passed_ms;
    op_o.success        = in_data_i.msg_success;
    op_o.inactivity_ms  = in_data_i.msg_inactivity_ms;
    op_o.tid            = in_data_i.msg_transaction_id;
  end

endmodule

FILE: rtl/core/skav_queue.sv
// Short queue of classified commands between the front and back parts.
// Depends on skav_pkg.
module skav_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  skav_pkg::op_item_t   op_i,
  input  logic                 pop_i,
  output skav_pkg::op_item_t   op_o,
  output skav_pkg::q_status_t  status_o
);
  import skav_pkg::*;

  op_item_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  assign op_o               = mem_q[rd_ptr_q];
  assign status_o.not_empty = (count_q != '0);
  assign status_o.full      = (count_q == QCntW'(QDepth));
  assign status_o.count     = count_q;

endmodule

FILE: rtl/core/skav_back.sv
// Back part: session state, timers, configuration registers and result buffer.
// Depends on skav_pkg; takes commands from skav_queue.
module skav_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  skav_pkg::q_status_t  q_status_i,
  input  skav_pkg::op_item_t   q_op_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output skav_pkg::out_item_t  out_data_o
);
  import skav_pkg::*;

  localparam logic [15:0] TidInit      = 16'd0;
  localparam logic [15:0] TidClose     = 16'd1;
  localparam logic [15:0] TidKeepalive = 16'd2;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_DECIDE = 2'b10
  } state_e;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic out_item_t mk(input action_e a, input logic [15:0] t,
                                   input logic [31:0] i);
    out_item_t r;
    r.action         = a;
    r.transaction_id = t;
    r.inactivity_ms  = i;
    r.last           = 1'b0;
    return r;
  endfunction

  state_e      state_q, state_d;
  logic [31:0] ka_interval_q, inact_default_q, ka_timeout_q, init_timeout_q;
  logic        active_q, active_d, connected_q, connected_d, await_q, await_d;
  logic        lfs_q, lfs_d;
  logic [31:0] since_rx_q, since_rx_d, since_ka_q, since_ka_d;
  logic [31:0] conn_el_q, conn_el_d, limit_q, limit_d;
  op_item_t    op_q;
  logic [31:0] rx_sum_q, ka_sum_q, el_sum_q;
  logic [31:0] offered;
  out_item_t   res_c [2];
  logic [1:0]  res_n;
  out_item_t   buf_q [2];
  logic        head_q;
  logic [1:0]  cnt_q;
  logic        can_load, commit, out_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ka_interval_q   <= KaIntervalRst;
      inact_default_q <= InactDefaultRst;
      ka_timeout_q    <= KaTimeoutRst;
      init_timeout_q  <= InitTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KA_INTERVAL:   ka_interval_q   <= cfg_wdata_i;
        CFG_INACT_DEFAULT: inact_default_q <= cfg_wdata_i;
        CFG_KA_TIMEOUT:    ka_timeout_q    <= cfg_wdata_i;
        CFG_INIT_TIMEOUT:  init_timeout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign offered  = lfs_q ? limit_q : inact_default_q;
  assign out_pop  = out_valid_o && out_ready_i;
  assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign commit   = (state_q == ST_DECIDE) && can_load;
  assign pop_o    = (state_q == ST_IDLE) && q_status_i.not_empty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (pop_o)  state_d = ST_DECIDE;
      ST_DECIDE: if (commit) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Decision step: the sums were registered when the command was taken from the queue.
  always_comb begin
    logic close;
    active_d    = active_q;
    connected_d = connected_q;
    await_d     = await_q;
    lfs_d       = lfs_q;
    since_rx_d  = since_rx_q;
    since_ka_d  = since_ka_q;
    conn_el_d   = conn_el_q;
    limit_d     = limit_q;
    res_c[0]    = '0;
    res_c[1]    = '0;
    res_n       = 2'd0;
    close       = 1'b0;
    unique case (op_q.cmd)
      CMD_CONNECT: begin
        if (!connected_q) begin
          since_rx_d = '0;
          since_ka_d = '0;
          conn_el_d  = '0;
          await_d    = 1'b0;
          active_d   = 1'b1;
          res_c[0]   = mk(ACT_SEND_INIT, TidInit, offered);
          res_n      = 2'd1;
        end
      end
      CMD_TICK: begin
        if (active_q) begin
          since_rx_d = rx_sum_q;
          if (!connected_q) begin
            conn_el_d = el_sum_q;
          end
          if ((rx_sum_q >= ka_interval_q) && !await_q) begin
            res_c[0]   = mk(ACT_SEND_KEEPALIVE, TidKeepalive, '0);
            res_n      = 2'd1;
            since_ka_d = '0;
            await_d    = 1'b1;
          end else if (await_q) begin
            if (since_ka_q >= ka_timeout_q) begin
              await_d = 1'b0;
              close   = 1'b1;
            end else begin
              since_ka_d = ka_sum_q;
            end
          end
          if (!close && !connected_q && (el_sum_q > init_timeout_q)) begin
            close = 1'b1;
          end
          // The idle counter wraps once it passes the inactivity limit.
          if (!close && (rx_sum_q > offered)) begin
            since_rx_d = '0;
          end
        end
      end
      CMD_MESSAGE: begin
        if (active_q && (op_q.mclass != MC_IGNORE)) begin
          since_rx_d = '0;
          unique case (op_q.mclass)
            MC_INIT_RESP: begin
              if (!connected_q) begin
                if (op_q.success) begin
                  connected_d = 1'b1;
                  limit_d     = op_q.inactivity_ms;
                  lfs_d       = 1'b1;
                  res_c[0]    = mk(ACT_SUCCEEDED, '0, '0);
                end else begin
                  active_d = 1'b0;
                  res_c[0] = mk(ACT_FAILED, '0, '0);
                end
                res_n = 2'd1;
              end
            end
            MC_CLOSE_REQ: begin
              res_c[0]    = mk(ACT_SEND_CLOSE_RESP, op_q.tid, '0);
              res_c[1]    = mk(ACT_CLOSED, '0, '0);
              res_n       = 2'd2;
              connected_d = 1'b0;
              active_d    = 1'b0;
            end
            MC_KA_RESP: begin
              if (await_q) begin
                await_d    = 1'b0;
                since_ka_d = '0;
              end
            end
            MC_FORWARD: begin
              res_c[0] = mk(ACT_FORWARD, '0, '0);
              res_n    = 2'd1;
            end
            default: ;
          endcase
        end
      end
      CMD_HOST_CLOSE: close = 1'b1;
      default: ;
    endcase
    if (close) begin
      if (connected_q) begin
        res_c[res_n[0]] = mk(ACT_SEND_CLOSE_REQ, TidClose, '0);
        res_n           = res_n + 2'd1;
      end
      res_c[res_n[0]] = mk(ACT_CLOSED, '0, '0);
      res_n           = res_n + 2'd1;
      connected_d     = 1'b0;
      active_d        = 1'b0;
    end
    if (res_n == 2'd1) begin
      res_c[0].last = 1'b1;
    end else if (res_n == 2'd2) begin
      res_c[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      connected_q <= 1'b0;
      await_q     <= 1'b0;
      lfs_q       <= 1'b0;
      since_rx_q  <= '0;
      since_ka_q  <= '0;
      conn_el_q   <= '0;
      limit_q     <= '0;
      head_q      <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        active_q    <= active_d;
        connected_q <= connected_d;
        await_q     <= await_d;
        lfs_q       <= lfs_d;
        since_rx_q  <= since_rx_d;
        since_ka_q  <= since_ka_d;
        conn_el_q   <= conn_el_d;
        limit_q     <= limit_d;
        head_q      <= 1'b0;
        cnt_q       <= res_n;
      end else if (out_pop) begin
        head_q <= ~head_q;
        cnt_q  <= cnt_q - 2'd1;
      end
    end
  end

  // Payload registers: the command and its saturated sums, then the results.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q     <= q_op_i;
      rx_sum_q <= sat_add(since_rx_q, q_op_i.time_passed_ms);
      ka_sum_q <= sat_add(since_ka_q, q_op_i.time_passed_ms);
      el_sum_q <= sat_add(conn_el_q, q_op_i.time_passed_ms);
    end
    if (commit) begin
      buf_q[0] <= res_c[0];
      buf_q[1] <= res_c[1];
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[head_q];

endmodule

FILE: rtl/core/session_keepalive_supervisor_unit.sv
// Top level of the session keepalive supervisor.
// Depends on skav_pkg, skav_front, skav_queue and skav_back.
//
// Usage: one command per input beat (connect, time tick, received message or
// host close) on in_valid_i/in_ready_o/in_data_i. Each command gives zero,
// one or two result beats on out_valid_o/out_ready_i/out_data_o; the last
// beat of a command has last set. Commands that give no result leave no trace
// on the output channel.
// The user writes the four timing registers through cfg_we_i/cfg_idx_i/cfg_wdata_i,
// one register per cycle, only while the block is idle; the block does not check it.
// The back part's two-step sequencer takes one command at a time from the queue:
// the first step forms the saturated timer sums and registers them, the second
// compares them, updates the session state and loads the two-entry result buffer,
// waiting while that buffer cannot take the results. The results of a command
// drain from the buffer while the next command's sums are formed.
// Reset clears the session flags and timers, returns the timing registers to
// their defaults and empties the two-entry command queue.
// When the receiver stalls, the result buffer holds, the back part waits,
// the queue fills and in_ready_o falls once it holds two commands.
module session_keepalive_supervisor_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  skav_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output skav_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i
);
  import skav_pkg::*;

  logic      push, pop;
  op_item_t  op_front, op_queue;
  q_status_t q_status;

  skav_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .op_o       (op_front)
  );

  skav_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (op_front),
    .pop_i    (pop),
    .op_o     (op_queue),
    .status_o (q_status)
  );

  skav_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_status_i  (q_status),
    .q_op_i      (op_queue),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // A beat that is not the last of its command is always followed by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last) |=> out_valid_o)
    else $error("result beat missing after a non-last beat");

  // Close requests and close responses are never marked as the last beat of a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_data_o.action == ACT_SEND_CLOSE_REQ) ||
                     (out_data_o.action == ACT_SEND_CLOSE_RESP))) |-> !out_data_o.last)
    else $error("close send marked as last beat");

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= QCntW'(QDepth))
    else $error("command queue overflow");

  // The back part pops only a non-empty queue, and a pop with no push lowers the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (q_status.count == $past(q_status.count) - QCntW'(1)))
    else $error("queue count out of step with pops");
`endif

endmodule

FILE: bench/session_keepalive_supervisor_unit_tb.sv
// Self-checking bench for the session keepalive supervisor top level.
// Depends on skav_pkg and session_keepalive_supervisor_unit; runs a directed table
// and then random traffic against its own model of the session timers.
module session_keepalive_supervisor_unit_tb;
  import skav_pkg::*;

  localparam int unsigned SettleCycles = 12;
  localparam int unsigned SettleBound  = 5000;
  localparam out_item_t   NoBeat       = '0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    int        n;
    out_item_t r0;
    out_item_t r1;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  // Model copy of the timing registers and session state.
  logic [31:0] ka_interval, inact_default, ka_timeout, init_timeout;
  logic        sess_up, linked, ka_pending, lim_from_srv;
  logic [31:0] idle_ms, ka_wait_ms, conn_ms, srv_limit_ms;

  out_item_t   fresh[$];
  out_item_t   due_results[$];
  stim_row_t   rows[$];

  int unsigned mismatches  = 0;
  int unsigned cmds_sent   = 0;
  int unsigned beats_seen  = 0;
  int unsigned phases_run  = 0;
  int unsigned tick_max    = 1000;
  bit          gaps_on     = 1'b1;

  session_keepalive_supervisor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH: %s", what);
  endtask

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] offered_ms();
    return lim_from_srv ? srv_limit_ms : inact_default;
  endfunction

  function automatic out_item_t mk_res(input action_e a, input logic [15:0] tid,
                                       input logic [31:0] ia, input logic lst);
    out_item_t r;
    r.action = a;
    r.transaction_id = tid;
    r.inactivity_ms = ia;
    r.last = lst;
    return r;
  endfunction

  function automatic in_item_t mk_cmd(input cmd_e c, input logic [15:0] t, input logic [3:0] k,
                                      input logic s, input logic [31:0] ia,
                                      input logic [15:0] tid);
    in_item_t it;
    it.command = c;
    it.time_passed_ms = t;
    it.msg_kind = k;
    it.msg_success = s;
    it.msg_inactivity_ms = ia;
    it.msg_transaction_id = tid;
    return it;
  endfunction

  function automatic void drop_session();
    if (linked) fresh.push_back(mk_res(ACT_SEND_CLOSE_REQ, 16'd1, 32'd0, 1'b0));
    linked = 1'b0;
    sess_up = 1'b0;
    fresh.push_back(mk_res(ACT_CLOSED, 16'd0, 32'd0, 1'b0));
  endfunction

  function automatic void timer_tick(input logic [31:0] t);
    if (!sess_up) return;
    idle_ms = sat_sum(idle_ms, t);
    if (!linked) conn_ms = sat_sum(conn_ms, t);
    if (idle_ms >= ka_interval && !ka_pending) begin
      fresh.push_back(mk_res(ACT_SEND_KEEPALIVE, 16'd2, 32'd0, 1'b0));
      ka_wait_ms = '0;
      ka_pending = 1'b1;
    end else if (ka_pending) begin
      if (ka_wait_ms >= ka_timeout) begin
        ka_pending = 1'b0;
        drop_session();
        return;
      end
      ka_wait_ms = sat_sum(ka_wait_ms, t);
    end
    if (!linked && conn_ms > init_timeout) begin
      drop_session();
      return;
    end
    if (idle_ms > offered_ms()) idle_ms = '0;
  endfunction

  function automatic void message_in(input in_item_t it);
    if (!sess_up || it.msg_kind > MSG_PDU_LAST) return;
    case (it.msg_kind)
      MSG_INIT_RESP: begin
        if (!linked) begin
          if (it.msg_success) begin
            linked = 1'b1;
            srv_limit_ms = it.msg_inactivity_ms;
            lim_from_srv = 1'b1;
            fresh.push_back(mk_res(ACT_SUCCEEDED, 16'd0, 32'd0, 1'b0));
          end else begin
            sess_up = 1'b0;
            fresh.push_back(mk_res(ACT_FAILED, 16'd0, 32'd0, 1'b0));
          end
        end
      end
      MSG_CLOSE_REQ: begin
        fresh.push_back(mk_res(ACT_SEND_CLOSE_RESP, it.msg_transaction_id, 32'd0, 1'b0));
        linked = 1'b0;
        sess_up = 1'b0;
        fresh.push_back(mk_res(ACT_CLOSED, 16'd0, 32'd0, 1'b0));
      end
      MSG_KA_RESP: begin
        if (ka_pending) begin
          ka_pending = 1'b0;
          ka_wait_ms = '0;
        end
      end
      MSG_INIT_REQ, MSG_CLOSE_RESP, MSG_KA_REQ: ;
      default: fresh.push_back(mk_res(ACT_FORWARD, 16'd0, 32'd0, 1'b0));
    endcase
    idle_ms = '0;
  endfunction

  // Works out the result beats of one command into fresh.
  function automatic void predict_beats(input in_item_t it);
    fresh.delete();
    case (cmd_e'(it.command))
      CMD_CONNECT: begin
        if (!linked) begin
          idle_ms = '0;
          ka_wait_ms = '0;
          conn_ms = '0;
          ka_pending = 1'b0;
          sess_up = 1'b1;
          fresh.push_back(mk_res(ACT_SEND_INIT, 16'd0, offered_ms(), 1'b0));
        end
      end
      CMD_TICK:    timer_tick({16'd0, it.time_passed_ms});
      CMD_MESSAGE: message_in(it);
      default:     drop_session();
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endfunction

  task automatic add_row(input in_item_t it, input bit typed, input int n,
                         input out_item_t r0, input out_item_t r1);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.n = n;
    row.r0 = r0;
    row.r1 = r1;
    rows.push_back(row);
  endtask

  // Sends one command beat and, once it is accepted, books its model results if use_model is set.
  task automatic push_cmd(input in_item_t it, input bit use_model);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk_i); while (!in_ready);
    cmds_sent++;
    predict_beats(it);
    if (use_model) foreach (fresh[i]) due_results.push_back(fresh[i]);
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid = 1'b0;
    while (due_results.size() != 0 && waited < SettleBound) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] v);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = v;
    case (idx)
      CFG_KA_INTERVAL:   ka_interval = v;
      CFG_INACT_DEFAULT: inact_default = v;
      CFG_KA_TIMEOUT:    ka_timeout = v;
      default:           init_timeout = v;
    endcase
  endtask

  task automatic set_timing(input logic [31:0] iv, input logic [31:0] dv,
                            input logic [31:0] tv, input logic [31:0] nv);
    write_reg(CFG_KA_INTERVAL, iv);
    write_reg(CFG_INACT_DEFAULT, dv);
    write_reg(CFG_KA_TIMEOUT, tv);
    write_reg(CFG_INIT_TIMEOUT, nv);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic logic [15:0] pick_ms();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, tick_max));
  endfunction

  // Mostly well-formed session traffic steered by the model state, plus noise.
  function automatic in_item_t pick_cmd();
    in_item_t    it;
    int unsigned r;
    it.command = 2'($urandom_range(0, 3));
    it.time_passed_ms = pick_ms();
    it.msg_kind = 4'($urandom_range(0, 15));
    it.msg_success = 1'($urandom_range(0, 1));
    it.msg_inactivity_ms = $urandom_range(0, 1) ? $urandom : $urandom_range(0, tick_max * 8);
    it.msg_transaction_id = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 12) return it;
    if (!sess_up) begin
      it.command = CMD_CONNECT;
    end else if (!linked) begin
      if (r < 50) begin
        it.command = CMD_MESSAGE;
        it.msg_kind = MSG_INIT_RESP;
        it.msg_success = ($urandom_range(0, 9) != 0);
      end else if (r < 92) begin
        it.command = CMD_TICK;
      end else begin
        it.command = CMD_CONNECT;
      end
    end else begin
      if (r < 60) begin
        it.command = CMD_TICK;
      end else if (r < 72) begin
        it.command = CMD_MESSAGE;
        it.msg_kind = MSG_KA_RESP;
      end else if (r < 88) begin
        it.command = CMD_MESSAGE;
        it.msg_kind = 4'($urandom_range(MSG_PDU_FIRST, MSG_PDU_LAST));
      end else if (r < 92) begin
        it.command = CMD_MESSAGE;
        it.msg_kind = MSG_CLOSE_REQ;
      end else if (r < 95) begin
        it.command = CMD_HOST_CLOSE;
      end else if (r < 97) begin
        it.command = CMD_CONNECT;
      end else begin
        it.command = CMD_MESSAGE;
        it.msg_kind = 4'($urandom_range(MSG_INIT_REQ, MSG_KA_RESP));
      end
    end
    return it;
  endfunction

  task automatic random_phase(input int unsigned n);
    repeat (n) begin
      push_cmd(pick_cmd(), 1'b1);
      // Now and then the sender waits for the output to drain completely.
      if ($urandom_range(0, 199) == 0) settle();
    end
    settle();
    phases_run++;
  endtask

  always @(negedge clk_i) begin
    out_ready = gaps_on ? ($urandom_range(0, 99) >= 21) : 1'b1;
  end

  always @(posedge clk_i) begin : check_beat
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing pending: action %0d tid %0d inact %0d last %0d",
                                out_data.action, out_data.transaction_id,
                                out_data.inactivity_ms, out_data.last));
      end else begin
        want = due_results.pop_front();
        beats_seen++;
        if (out_data.action !== want.action ||
            out_data.transaction_id !== want.transaction_id ||
            out_data.inactivity_ms !== want.inactivity_ms ||
            out_data.last !== want.last) begin
          flag_mismatch($sformatf(
            "beat %0d: got action %0d tid %0d inact %0d last %0d, want %0d %0d %0d %0d",
            beats_seen, out_data.action, out_data.transaction_id, out_data.inactivity_ms,
            out_data.last, want.action, want.transaction_id, want.inactivity_ms, want.last));
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Run timed out with %0d result beats still pending", due_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_KA_INTERVAL;
    cfg_wdata = '0;
    ka_interval = KaIntervalRst;
    inact_default = InactDefaultRst;
    ka_timeout = KaTimeoutRst;
    init_timeout = InitTimeoutRst;
    sess_up = 1'b0;
    linked = 1'b0;
    ka_pending = 1'b0;
    lim_from_srv = 1'b0;
    idle_ms = '0;
    ka_wait_ms = '0;
    conn_ms = '0;
    srv_limit_ms = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, run on the register defaults.
    add_row(mk_cmd(CMD_TICK, 16'd100, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b1, 0, NoBeat, NoBeat);
    add_row(mk_cmd(CMD_HOST_CLOSE, 16'd0, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b1, 1,
            mk_res(ACT_CLOSED, 16'd0, 32'd0, 1'b1), NoBeat);
    add_row(mk_cmd(CMD_CONNECT, 16'd0, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b1, 1,
            mk_res(ACT_SEND_INIT, 16'd0, InactDefaultRst, 1'b1), NoBeat);
    // A second connect before the server answers restarts the session.
    add_row(mk_cmd(CMD_CONNECT, 16'hFFFF, 4'hF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, 1,
            mk_res(ACT_SEND_INIT, 16'd0, InactDefaultRst, 1'b1), NoBeat);
    // Init timeout without a connection closes with no close request.
    add_row(mk_cmd(CMD_TICK, 16'd5001, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b1, 1,
            mk_res(ACT_CLOSED, 16'd0, 32'd0, 1'b1), NoBeat);
    add_row(mk_cmd(CMD_CONNECT, 16'd0, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b1, 1,
            mk_res(ACT_SEND_INIT, 16'd0, InactDefaultRst, 1'b1), NoBeat);
    add_row(mk_cmd(CMD_MESSAGE, 16'd0, MSG_INIT_RESP, 1'b0, 32'd0, 16'd0), 1'b1, 1,
            mk_res(ACT_FAILED, 16'd0, 32'd0, 1'b1), NoBeat);
    add_row(mk_cmd(CMD_CONNECT, 16'd0, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b1, 1,
            mk_res(ACT_SEND_INIT, 16'd0, InactDefaultRst, 1'b1), NoBeat);
    // Keepalive goes out and the init timeout fires on the same tick.
    add_row(mk_cmd(CMD_TICK, 16'd30000, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b0, 0,
            NoBeat, NoBeat);
    add_row(mk_cmd(CMD_CONNECT, 16'd0, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b1, 1,
            mk_res(ACT_SEND_INIT, 16'd0, InactDefaultRst, 1'b1), NoBeat);
    add_row(mk_cmd(CMD_MESSAGE, 16'd0, MSG_INIT_RESP, 1'b1, 32'hFFFF_FFFF, 16'd0), 1'b1, 1,
            mk_res(ACT_SUCCEEDED, 16'd0, 32'd0, 1'b1), NoBeat);
    // Connect while connected is dropped.
    add_row(mk_cmd(CMD_CONNECT, 16'd0, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b1, 0,
            NoBeat, NoBeat);
    add_row(mk_cmd(CMD_TICK, 16'hFFFF, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b0, 0, NoBeat, NoBeat);
    add_row(mk_cmd(CMD_TICK, 16'd0, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b0, 0, NoBeat, NoBeat);
    add_row(mk_cmd(CMD_MESSAGE, 16'd0, MSG_KA_RESP, 1'b0, 32'd0, 16'd0), 1'b0, 0,
            NoBeat, NoBeat);
    add_row(mk_cmd(CMD_MESSAGE, 16'd0, MSG_CLOSE_RESP, 1'b0, 32'd0, 16'd0), 1'b0, 0,
            NoBeat, NoBeat);
    add_row(mk_cmd(CMD_MESSAGE, 16'd0, MSG_PDU_LAST, 1'b0, 32'd0, 16'd0), 1'b1, 1,
            mk_res(ACT_FORWARD, 16'd0, 32'd0, 1'b1), NoBeat);
    // Out-of-range kinds are dropped and leave the idle timer alone.
    add_row(mk_cmd(CMD_MESSAGE, 16'd0, 4'hF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, 0,
            NoBeat, NoBeat);
    add_row(mk_cmd(CMD_TICK, 16'hFFFF, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b0, 0, NoBeat, NoBeat);
    add_row(mk_cmd(CMD_TICK, 16'hFFFF, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b0, 0, NoBeat, NoBeat);
    // Keepalive response overdue while connected: close request, then closed.
    add_row(mk_cmd(CMD_TICK, 16'd1, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b0, 0, NoBeat, NoBeat);
    add_row(mk_cmd(CMD_CONNECT, 16'd0, MSG_INIT_REQ, 1'b0, 32'd0, 16'd0), 1'b0, 0,
            NoBeat, NoBeat);
    // A close request from the server is answered with a close response.
    add_row(mk_cmd(CMD_MESSAGE, 16'd0, MSG_CLOSE_REQ, 1'b0, 32'd0, 16'hFFFF), 1'b1, 2,
            mk_res(ACT_SEND_CLOSE_RESP, 16'hFFFF, 32'd0, 1'b0),
            mk_res(ACT_CLOSED, 16'd0, 32'd0, 1'b1));

    for (int i = 0; i < rows.size(); i++) begin
      push_cmd(rows[i].item, !rows[i].typed);
      if (rows[i].typed && rows[i].n > 0) due_results.push_back(rows[i].r0);
      if (rows[i].typed && rows[i].n > 1) due_results.push_back(rows[i].r1);
    end
    settle();

    tick_max = 12000;
    random_phase(300);

    set_timing(32'd100, 32'd300, 32'd50, 32'd80);
    tick_max = 60;
    random_phase(300);

    // All registers at zero, with neither side idling.
    set_timing(32'd0, 32'd0, 32'd0, 32'd0);
    gaps_on = 1'b0;
    tick_max = 3;
    random_phase(250);
    gaps_on = 1'b1;

    set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    tick_max = 65535;
    random_phase(250);

    set_timing($urandom_range(0, 2000), $urandom_range(0, 4000), $urandom_range(0, 1000),
               $urandom_range(0, 1500));
    tick_max = 500;
    random_phase(300);

    set_timing($urandom, $urandom_range(0, 200000), $urandom_range(0, 70000),
               $urandom_range(0, 200000));
    tick_max = 65535;
    random_phase(300);

    if (due_results.size() != 0)
      flag_mismatch($sformatf("%0d result beats never arrived", due_results.size()));
    $display("Run covered %0d commands over the directed table and %0d random phases,",
             cmds_sent, phases_run);
    $display("checking %0d result beats across default, zero, maximum and random timings.",
             beats_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
